/* rtl/cmli_pkg.sv */
// shared types and constants for the linear-interpolating colormap
package cmli_pkg;

   // fixed field widths
   localparam int SampleBits   = 16;
   localparam int ColorBits    = 8;
   localparam int IndexBits    = 8;
   localparam int CountBits    = 9;
   localparam int CsrDataBits  = 16;
   localparam int CsrIndexBits = 2;

   // csr register indexes
   localparam logic [CsrIndexBits-1:0] CSR_MIN_VALUE   = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_VALUE   = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_ENTRY_COUNT = 2'd2;

   // entry count after reset
   localparam logic [CountBits-1:0] CountReset = 9'd256;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;

   typedef struct packed {
      logic [ColorBits-1:0] red;
      logic [ColorBits-1:0] green;
      logic [ColorBits-1:0] blue;
   } color_type;

   typedef struct packed {
      logic                  req_type;
      logic [IndexBits-1:0]  entry_index;
      logic [ColorBits-1:0]  red_in;
      logic [ColorBits-1:0]  green_in;
      logic [ColorBits-1:0]  blue_in;
      logic [SampleBits-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [ColorBits-1:0] red;
      logic [ColorBits-1:0] green;
      logic [ColorBits-1:0] blue;
      logic                 clamped;
   } rsp_item_type;

   // table write carried down the pipeline with each request
   typedef struct packed {
      logic [IndexBits-1:0] entry_index;
      color_type            color;
   } load_type;

   // per-stage control
   typedef struct packed {
      logic valid;
      logic load;
      logic clamped;
   } ctl_type;

endpackage

/* rtl/colormap_linear_interp.sv */
// top level of the linear-interpolating colormap lookup
//
//   channel   ports                            moves
//   request   req_valid / req_stall / req_item one table load or one sample to map
//   response  rsp_valid / rsp_stall / rsp_item interpolated color and clamp flag
//   csr       csr_wr_en / csr_index / csr_data min, max and entry count writes
//
// One request per cycle while req_stall is low. A mapped sample enters the first of
// index-bits + 4 segment stages when it is taken, then one table read stage and ten
// blend stages, the last of them the response register.
// Loads write the table in request order and give no response.
// Reset is synchronous; it clears the pipeline valids and the csr registers, the table
// keeps its contents and needs loading before use.
// A stalled response holds the output stage; empty stages upstream keep taking requests.
module colormap_linear_interp
   import cmli_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_item,
   input  logic                    csr_wr_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data
);

   localparam int SW       = (SAMPLE_BITS < SampleBits) ? SAMPLE_BITS : SampleBits;
   localparam int CountMax = (1 << CountBits) - 1;
   localparam int CntTop   = (TABLE_DEPTH < CountMax) ? TABLE_DEPTH : CountMax;
   localparam int QW       = $clog2(CntTop);

   logic [SW-1:0]        min_ff;
   logic [SW-1:0]        max_ff;
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] cnt_eff;
   logic [SW-1:0]        span_ff;
   logic [SW-1:0]        span_in;
   logic                 flat_ff;
   logic                 flat_in;
   logic [QW-1:0]        cntm1_ff;
   logic [QW-1:0]        cntm1_in;

   ctl_type              seg_ctl;
   logic [QW-1:0]        seg_k;
   logic [SW:0]          seg_rem;
   load_type             seg_load;
   logic                 tab_ready;
   ctl_type              tab_ctl;
   logic [SW:0]          tab_rem;
   color_type            tab_e0;
   color_type            tab_e1;
   logic                 blend_ready;
   logic                 seg_ready;
   ctl_type              out_ctl;
   color_type            out_color;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= '1;
         count_ff <= CountReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_VALUE:   min_ff   <= csr_data[SW-1:0];
            CSR_MAX_VALUE:   max_ff   <= csr_data[SW-1:0];
            CSR_ENTRY_COUNT: count_ff <= csr_data[CountBits-1:0];
            default: ;
         endcase
      end
   end

   // span, flat range and clipped count, registered for the divide stages
   always_comb begin
      flat_in = (max_ff <= min_ff);
      span_in = flat_in ? SW'(1) : (max_ff - min_ff);
      if (count_ff < CountBits'(2)) begin
         cnt_eff = CountBits'(2);
      end else if (count_ff > CountBits'(CntTop)) begin
         cnt_eff = CountBits'(CntTop);
      end else begin
         cnt_eff = count_ff;
      end
      cntm1_in = QW'(cnt_eff - CountBits'(1));
   end

   always_ff @(posedge clock) begin
      span_ff  <= span_in;
      flat_ff  <= flat_in;
      cntm1_ff <= cntm1_in;
   end

   // segment index and remainder
   cmli_seg #(
      .SW (SW),
      .QW (QW)
   ) u_seg (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_item    (req_item),
      .up_ready   (seg_ready),
      .min_value  (min_ff),
      .max_value  (max_ff),
      .span       (span_ff),
      .flat       (flat_ff),
      .cntm1      (cntm1_ff),
      .down_ctl   (seg_ctl),
      .down_k     (seg_k),
      .down_rem   (seg_rem),
      .down_load  (seg_load),
      .down_ready (tab_ready)
   );

   assign req_stall = !seg_ready;

   // color table
   cmli_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SW          (SW),
      .QW          (QW)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .up_ctl     (seg_ctl),
      .up_k       (seg_k),
      .up_rem     (seg_rem),
      .up_load    (seg_load),
      .up_ready   (tab_ready),
      .down_ctl   (tab_ctl),
      .down_rem   (tab_rem),
      .down_e0    (tab_e0),
      .down_e1    (tab_e1),
      .down_ready (blend_ready)
   );

   // channel blend, its last stage is the response register
   cmli_blend #(
      .SW (SW)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .up_ctl     (tab_ctl),
      .up_rem     (tab_rem),
      .up_e0      (tab_e0),
      .up_e1      (tab_e1),
      .span       (span_ff),
      .up_ready   (blend_ready),
      .down_ctl   (out_ctl),
      .down_color (out_color),
      .down_ready (!rsp_stall)
   );

   assign rsp_valid = out_ctl.valid;
   assign rsp_item  = {out_color, out_ctl.clamped};

   // pipeline comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

/* rtl/cmli_seg.sv */
// segment finder: clamp, scale and divide by the range span to get entry index and remainder
module cmli_seg
   import cmli_pkg::*;
#(
   parameter int SW = 16,
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  req_item_type  up_item,
   output logic          up_ready,
   input  logic [SW-1:0] min_value,
   input  logic [SW-1:0] max_value,
   input  logic [SW-1:0] span,
   input  logic          flat,
   input  logic [QW-1:0] cntm1,
   output ctl_type       down_ctl,
   output logic [QW-1:0] down_k,
   output logic [SW:0]   down_rem,
   output load_type      down_load,
   input  logic          down_ready
);

   localparam int NS     = QW + 4;
   localparam int LastSt = NS - 1;
   localparam int ZW     = SW + QW;

   ctl_type       ctl_ff  [NS];
   load_type      load_ff [NS];
   logic [NS:0]   rdy;
   logic [SW-1:0] samp_ff;
   logic [SW-1:0] diff_ff;
   logic [SW-1:0] diff_in;
   ctl_type       ctl1_in;
   logic [ZW-1:0] z_ff [QW+1];
   logic [ZW-1:0] z_in [QW+1];
   logic [QW-1:0] k_ff;
   logic [QW-1:0] k_in;
   logic [SW:0]   rem_ff;
   logic [SW:0]   rem_in;

   // ready chain, a stage moves when empty or when the next one moves
   assign rdy[NS] = down_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !ctl_ff[i].valid || rdy[i+1];
   end

   assign up_ready = rdy[0];

   // clamp sample to range and take offset from min
   always_comb begin
      logic          below_min;
      logic          above_max;
      logic [SW-1:0] clip_val;
      below_min = samp_ff < min_value;
      above_max = samp_ff > max_value;
      if (below_min) begin
         clip_val = min_value;
      end else if (above_max) begin
         clip_val = max_value;
      end else begin
         clip_val = samp_ff;
      end
      diff_in = clip_val - min_value;
      ctl1_in = ctl_ff[0];
      ctl1_in.clamped = below_min || above_max;
   end

   // scaled offset, then one restoring divide step per stage
   always_comb begin
      logic [SW-1:0] part;
      logic [QW-1:0] low;
      logic [SW:0]   trial;
      logic          qbit;
      logic [QW:0]   shifted;
      part    = '0;
      low     = '0;
      trial   = '0;
      qbit    = 1'b0;
      shifted = '0;
      z_in[0] = {{SW{1'b0}}, cntm1} * {{QW{1'b0}}, diff_ff};
      for (int j = 0; j < QW; j++) begin
         part  = z_ff[j][ZW-1:QW];
         low   = z_ff[j][QW-1:0];
         trial = {part, low[QW-1]};
         if (trial >= {1'b0, span}) begin
            trial = trial - {1'b0, span};
            qbit  = 1'b1;
         end else begin
            qbit  = 1'b0;
         end
         shifted   = {low, qbit};
         z_in[j+1] = {trial[SW-1:0], shifted[QW-1:0]};
      end
   end

   // top sample lands on the last segment, flat range reads entry 0
   always_comb begin
      logic [QW-1:0] quo;
      logic [SW-1:0] part;
      quo  = z_ff[QW][QW-1:0];
      part = z_ff[QW][ZW-1:QW];
      if (flat) begin
         k_in   = '0;
         rem_in = '0;
      end else if (quo >= cntm1) begin
         k_in   = cntm1 - QW'(1);
         rem_in = {1'b0, part} + {1'b0, span};
      end else begin
         k_in   = quo;
         rem_in = {1'b0, part};
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         if (rdy[0]) begin
            ctl_ff[0] <= '{valid: up_valid, load: (up_item.req_type == REQ_LOAD),
                           clamped: 1'b0};
         end
         if (rdy[1]) begin
            ctl_ff[1] <= ctl1_in;
         end
         for (int i = 2; i < NS; i++) begin
            if (rdy[i]) begin
               ctl_ff[i] <= ctl_ff[i-1];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         samp_ff    <= up_item.sample[SW-1:0];
         load_ff[0] <= {up_item.entry_index, up_item.red_in, up_item.green_in,
                        up_item.blue_in};
      end
      for (int i = 1; i < NS; i++) begin
         if (rdy[i]) begin
            load_ff[i] <= load_ff[i-1];
         end
      end
      if (rdy[1]) begin
         diff_ff <= diff_in;
      end
      for (int j = 0; j <= QW; j++) begin
         if (rdy[j+2]) begin
            z_ff[j] <= z_in[j];
         end
      end
      if (rdy[LastSt]) begin
         k_ff   <= k_in;
         rem_ff <= rem_in;
      end
   end

   assign down_ctl  = ctl_ff[LastSt];
   assign down_load = load_ff[LastSt];
   assign down_k    = k_ff;
   assign down_rem  = rem_ff;

   // a finished request waits at the end of the segment pipeline
   a_seg_hold: assert property (@(posedge clock) disable iff (reset)
      down_ctl.valid && !down_ready |=> down_ctl.valid && $stable(down_k))
      else $error("segment result lost while stalled");

endmodule

/* rtl/cmli_table.sv */
// color table memory: in-order loads and two-entry reads for each mapped sample
module cmli_table
   import cmli_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int SW          = 16,
   parameter int QW          = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       up_ctl,
   input  logic [QW-1:0] up_k,
   input  logic [SW:0]   up_rem,
   input  load_type      up_load,
   output logic          up_ready,
   output ctl_type       down_ctl,
   output logic [SW:0]   down_rem,
   output color_type     down_e0,
   output color_type     down_e1,
   input  logic          down_ready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   color_type     mem [TABLE_DEPTH];
   ctl_type       ctl_ff;
   color_type     e0_ff;
   color_type     e1_ff;
   logic [SW:0]   rem_ff;
   logic          rdy;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;

   assign rdy      = !ctl_ff.valid || down_ready;
   assign up_ready = rdy;

   // loads beyond the table are dropped
   assign wr_en    = up_ctl.valid && up_ctl.load &&
                     (int'(up_load.entry_index) < TABLE_DEPTH);
   assign wr_addr  = AW'(up_load.entry_index);
   assign rd0_addr = AW'(up_k);
   assign rd1_addr = rd0_addr + AW'(1);

   // loads end here, only mapped samples move on
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (rdy) begin
         ctl_ff <= '{valid: up_ctl.valid && !up_ctl.load, load: 1'b0,
                     clamped: up_ctl.clamped};
      end
   end

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (rdy) begin
         if (wr_en) begin
            mem[wr_addr] <= up_load.color;
         end
         e0_ff  <= mem[rd0_addr];
         e1_ff  <= mem[rd1_addr];
         rem_ff <= up_rem;
      end
   end

   assign down_ctl = ctl_ff;
   assign down_rem = rem_ff;
   assign down_e0  = e0_ff;
   assign down_e1  = e1_ff;

   // a load never turns into a result
   a_load_drops: assert property (@(posedge clock) disable iff (reset)
      up_ctl.valid && up_ctl.load && rdy |=> !ctl_ff.valid)
      else $error("table load produced a result");

   // a mapped sample always reaches the read stage
   a_map_moves: assert property (@(posedge clock) disable iff (reset)
      up_ctl.valid && !up_ctl.load && rdy |=> ctl_ff.valid)
      else $error("mapped sample lost at table read");

endmodule

/* rtl/cmli_blend.sv */
// channel blend: weighted sum of two entries and a rounded divide by the span
module cmli_blend
   import cmli_pkg::*;
#(
   parameter int SW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       up_ctl,
   input  logic [SW:0]   up_rem,
   input  color_type     up_e0,
   input  color_type     up_e1,
   input  logic [SW-1:0] span,
   output logic          up_ready,
   output ctl_type       down_ctl,
   output color_type     down_color,
   input  logic          down_ready
);

   localparam int NCh = 3;
   localparam int NS  = ColorBits + 2;
   localparam int YW  = SW + ColorBits;

   ctl_type                         ctl_ff [NS];
   logic [NS:0]                     rdy;
   logic [NCh-1:0][ColorBits-1:0]   a_ch;
   logic [NCh-1:0][ColorBits-1:0]   b_ch;
   logic [NCh-1:0][ColorBits-1:0]   q_ch;
   logic [SW:0]                     wgt0;
   logic [YW-1:0]                   p0_ff [NCh];
   logic [YW-1:0]                   p1_ff [NCh];
   logic [YW-1:0]                   p0_in [NCh];
   logic [YW-1:0]                   p1_in [NCh];
   logic [YW-1:0]                   y_ff  [NCh][ColorBits+1];
   logic [YW-1:0]                   y_in  [NCh][ColorBits+1];

   // ready chain
   assign rdy[NS] = down_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !ctl_ff[i].valid || rdy[i+1];
   end

   assign up_ready = rdy[0];

   // weighted products of both entries
   always_comb begin
      logic [YW:0] prod0;
      logic [YW:0] prod1;
      prod0 = '0;
      prod1 = '0;
      a_ch  = up_e0;
      b_ch  = up_e1;
      // zero weight drops the upper entry, which a flat range may never have loaded
      if (up_rem == '0) begin
         b_ch = '0;
      end
      wgt0  = {1'b0, span} - up_rem;
      for (int c = 0; c < NCh; c++) begin
         prod0    = {{ColorBits{1'b0}}, wgt0} * {{(SW+1){1'b0}}, a_ch[c]};
         prod1    = {{ColorBits{1'b0}}, up_rem} * {{(SW+1){1'b0}}, b_ch[c]};
         p0_in[c] = prod0[YW-1:0];
         p1_in[c] = prod1[YW-1:0];
      end
   end

   // sum with half span for rounding, then one divide step per stage
   always_comb begin
      logic [SW-1:0]        part;
      logic [ColorBits-1:0] low;
      logic [SW:0]          trial;
      logic                 qbit;
      part  = '0;
      low   = '0;
      trial = '0;
      qbit  = 1'b0;
      for (int c = 0; c < NCh; c++) begin
         y_in[c][0] = p0_ff[c] + p1_ff[c] + {{ColorBits{1'b0}}, span >> 1};
         for (int j = 0; j < ColorBits; j++) begin
            part  = y_ff[c][j][YW-1:ColorBits];
            low   = y_ff[c][j][ColorBits-1:0];
            trial = {part, low[ColorBits-1]};
            if (trial >= {1'b0, span}) begin
               trial = trial - {1'b0, span};
               qbit  = 1'b1;
            end else begin
               qbit  = 1'b0;
            end
            y_in[c][j+1] = {trial[SW-1:0], low[ColorBits-2:0], qbit};
         end
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         if (rdy[0]) begin
            ctl_ff[0] <= up_ctl;
         end
         for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
               ctl_ff[i] <= ctl_ff[i-1];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int c = 0; c < NCh; c++) begin
         if (rdy[0]) begin
            p0_ff[c] <= p0_in[c];
            p1_ff[c] <= p1_in[c];
         end
         for (int j = 0; j <= ColorBits; j++) begin
            if (rdy[j+1]) begin
               y_ff[c][j] <= y_in[c][j];
            end
         end
      end
   end

   // quotient sits in the low bits after the last step
   always_comb begin
      for (int c = 0; c < NCh; c++) begin
         q_ch[c] = y_ff[c][ColorBits][ColorBits-1:0];
      end
   end

   assign down_color = q_ch;
   assign down_ctl   = ctl_ff[NS-1];

endmodule

/* dv/colormap_linear_interp_test.sv */
// self-checking testbench for the linear-interpolating colormap lookup
module colormap_linear_interp_test
   import cmli_pkg::*;
();

   localparam int CLOCK_PERIOD     = 20;
   localparam int TABLE_ENTRIES    = 256;
   localparam int PIPE_LATENCY     = 23;
   localparam int RANDOM_PHASES    = 8;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int TIMEOUT_CYCLES   = 200000;
   localparam int IDLE_PERCENT     = 22;
   localparam int LOAD_PERCENT     = 20;
   localparam int HOLD_CYCLES      = 150;
   localparam logic REQ_MAP        = ~REQ_LOAD;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_item_type            req_item = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_item_type            rsp_item;
   logic                    csr_wr_en = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_data = '0;

   // shadow of the block: color table and range registers
   color_type             palette [TABLE_ENTRIES];
   logic [SampleBits-1:0] lo_bound;
   logic [SampleBits-1:0] hi_bound;
   logic [CountBits-1:0]  count_reg;

   // requests waiting to be sent and colors waiting to come back
   req_item_type pending_reqs [$];
   rsp_item_type expected_colors [$];

   // what the stimulus side knows about the settings and the loaded entries
   logic [SampleBits-1:0]  gen_lo;
   logic [SampleBits-1:0]  gen_hi;
   int unsigned            gen_cnt;
   logic [TABLE_ENTRIES-1:0] gen_loaded = '0;

   int   queued_reqs = 0;
   int   accepted_reqs = 0;
   int   loads_taken = 0;
   int   maps_checked = 0;
   int   clamps_seen = 0;
   int   input_stalls = 0;
   int   settings_applied = 0;
   int   mismatch_count = 0;
   int   hold_left = 0;
   int   holds_done = 0;
   logic req_taken = 1'b0;
   logic quiet_stretch;

   colormap_linear_interp dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // no random idling on either side for a while in the middle of the run
   assign quiet_stretch = (accepted_reqs >= 900) && (accepted_reqs < 1250);

   // one rounded channel blend between neighboring entries
   function automatic logic [ColorBits-1:0] blend(input int unsigned a, b, rem, span);
      return ColorBits'((a * (span - rem) + b * rem + span / 2) / span);
   endfunction

   // expected color and clamp flag for one sample under the current settings
   function automatic rsp_item_type map_sample(input logic [SampleBits-1:0] raw);
      rsp_item_type result;
      int unsigned  s, cnt, span, num, k, rem;
      color_type    c0, c1;
      s = raw;
      result.clamped = 1'b0;
      if (s < lo_bound) begin
         result.clamped = 1'b1;
         s = lo_bound;
      end
      if (s > hi_bound) begin
         result.clamped = 1'b1;
         s = hi_bound;
      end
      if (hi_bound <= lo_bound) begin
         // empty or inverted range: first entry as it is
         c0 = palette[0];
         result.red   = c0.red;
         result.green = c0.green;
         result.blue  = c0.blue;
      end else begin
         cnt = count_reg;
         if (cnt < 2) cnt = 2;
         if (cnt > TABLE_ENTRIES) cnt = TABLE_ENTRIES;
         span = int'(hi_bound) - int'(lo_bound);
         num  = (cnt - 1) * (s - lo_bound);
         k    = num / span;
         if (k > cnt - 2) k = cnt - 2;
         rem  = num - k * span;
         c0 = palette[k];
         c1 = palette[k + 1];
         result.red   = blend(c0.red, c1.red, rem, span);
         result.green = blend(c0.green, c1.green, rem, span);
         result.blue  = blend(c0.blue, c1.blue, rem, span);
      end
      return result;
   endfunction

   // queue a table load; the unused sample field is random
   task automatic add_load(input logic [IndexBits-1:0] idx,
                           input logic [ColorBits-1:0] r, g, b);
      req_item_type item;
      item.req_type    = REQ_LOAD;
      item.entry_index = idx;
      item.red_in      = r;
      item.green_in    = g;
      item.blue_in     = b;
      item.sample      = SampleBits'($urandom);
      pending_reqs.push_back(item);
      gen_loaded[idx] = 1'b1;
      queued_reqs++;
   endtask

   // queue a sample, loading first any entry in use that was never written
   task automatic add_map(input logic [SampleBits-1:0] value);
      req_item_type item;
      for (int i = 0; i < gen_cnt; i++)
         if (!gen_loaded[i])
            add_load(IndexBits'(i), ColorBits'($urandom), ColorBits'($urandom),
                     ColorBits'($urandom));
      item.req_type    = REQ_MAP;
      item.entry_index = IndexBits'($urandom);
      item.red_in      = ColorBits'($urandom);
      item.green_in    = ColorBits'($urandom);
      item.blue_in     = ColorBits'($urandom);
      item.sample      = value;
      pending_reqs.push_back(item);
      queued_reqs++;
   endtask

   // wait until every request is taken and every color is back, then let the pipe empty
   task automatic drain();
      while (accepted_reqs != queued_reqs || expected_colors.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY + 8) @(negedge clock);
   endtask

   // write all three range registers while the block is idle
   task automatic apply_settings(input logic [SampleBits-1:0] lo, hi,
                                 input logic [CountBits-1:0] count);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MIN_VALUE;
      csr_data  <= lo;
      @(negedge clock);
      csr_index <= CSR_MAX_VALUE;
      csr_data  <= hi;
      @(negedge clock);
      csr_index <= CSR_ENTRY_COUNT;
      csr_data  <= CsrDataBits'(count);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gen_lo  = lo;
      gen_hi  = hi;
      gen_cnt = (count < 2) ? 2 : (count > TABLE_ENTRIES) ? TABLE_ENTRIES : count;
      settings_applied++;
   endtask

   // request side: offer the next pending request, hold it while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 &&
             (quiet_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_item  <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // register writes and accepted requests update the shadow and the expected colors
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         lo_bound  = '0;
         hi_bound  = '1;
         count_reg = CountReset;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_VALUE:   lo_bound = csr_data;
               CSR_MAX_VALUE:   hi_bound = csr_data;
               CSR_ENTRY_COUNT: count_reg = csr_data[CountBits-1:0];
               default: ;
            endcase
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && req_stall) input_stalls++;
         if (req_valid && !req_stall) begin
            accepted_reqs++;
            if (req_item.req_type == REQ_LOAD) begin
               palette[req_item.entry_index] = '{req_item.red_in, req_item.green_in,
                                                 req_item.blue_in};
               loads_taken++;
            end else begin
               expected_colors.push_back(map_sample(req_item.sample));
            end
         end
      end
   end

   // response side: random stalls plus two long hold-offs that back up the pipe
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_done < 2 && accepted_reqs >= 400 + 1100 * holds_done) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         holds_done++;
      end else begin
         rsp_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // compare each response with the oldest expected color
   always @(posedge clock) begin
      rsp_item_type want;
      logic         bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $display("%0t: response with nothing expected: %p", $time, rsp_item);
            mismatch_count++;
         end else begin
            want = expected_colors.pop_front();
            bad  = 1'b0;
            if (rsp_item.red !== want.red) begin
               $display("%0t: red expected %0d got %0d", $time, want.red, rsp_item.red);
               bad = 1'b1;
            end
            if (rsp_item.green !== want.green) begin
               $display("%0t: green expected %0d got %0d", $time, want.green,
                        rsp_item.green);
               bad = 1'b1;
            end
            if (rsp_item.blue !== want.blue) begin
               $display("%0t: blue expected %0d got %0d", $time, want.blue, rsp_item.blue);
               bad = 1'b1;
            end
            if (rsp_item.clamped !== want.clamped) begin
               $display("%0t: clamped expected %0d got %0d", $time, want.clamped,
                        rsp_item.clamped);
               bad = 1'b1;
            end
            if (bad) mismatch_count++;
            if (want.clamped) clamps_seen++;
            maps_checked++;
         end
      end
   end

   // stimulus: directed corners, then random traffic over several range settings
   initial begin
      logic [SampleBits-1:0] lo, hi, value;
      logic [CountBits-1:0]  count;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // two-entry table over a narrow range
      apply_settings(16'd100, 16'd1000, 9'd2);
      add_load(8'd0, 8'h00, 8'h00, 8'h00);
      add_load(8'd1, 8'hff, 8'hff, 8'hff);
      // entry past the count but inside the table
      add_load(8'd255, 8'haa, 8'h55, 8'hf0);
      // below, above and at both edges of the range
      add_map(16'd0);
      add_map(16'hffff);
      add_map(16'd100);
      add_map(16'd1000);
      // exactly half way, rounds up
      add_map(16'd550);
      add_map(16'd101);
      add_map(16'd999);
      // reload an entry right before a sample that reads it
      add_load(8'd1, 8'd10, 8'd20, 8'd30);
      add_map(16'd1000);

      // empty range
      apply_settings(16'd500, 16'd500, 9'd2);
      add_map(16'd499);
      add_map(16'd500);
      add_map(16'd501);

      // inverted range
      apply_settings(16'd600, 16'd200, 9'd2);
      add_map(16'd100);
      add_map(16'd700);

      // count below two, full sample range
      apply_settings(16'd0, 16'hffff, 9'd0);
      add_map(16'd0);
      add_map(16'hffff);
      add_map(16'h8000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               lo = 16'd0;
               hi = 16'hffff;
               count = 9'd256;
            end
            1: begin
               lo = 16'd0;
               hi = 16'hffff;
               count = 9'd511;
            end
            2: begin
               // span of one, all samples land in the last segment or the first
               lo = 16'd0;
               hi = 16'd1;
               count = 9'd256;
            end
            3: begin
               lo = 16'hffff;
               hi = 16'd0;
               count = CountBits'($urandom_range(511));
            end
            4: begin
               lo = SampleBits'($urandom_range(30000));
               hi = SampleBits'($urandom_range(65535, 30001));
               count = 9'd1;
            end
            5: begin
               lo = SampleBits'($urandom_range(60000));
               hi = lo + SampleBits'($urandom_range(400, 1));
               count = CountBits'($urandom_range(256, 2));
            end
            6: begin
               lo = SampleBits'($urandom_range(65535));
               hi = SampleBits'($urandom_range(65535));
               count = CountBits'($urandom_range(511));
            end
            default: begin
               lo = 16'd0;
               hi = 16'hffff;
               count = 9'd2;
            end
         endcase
         apply_settings(lo, hi, count);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(99) < LOAD_PERCENT) begin
               add_load(IndexBits'($urandom), ColorBits'($urandom), ColorBits'($urandom),
                        ColorBits'($urandom));
            end else begin
               case ($urandom_range(9))
                  0: value = SampleBits'($urandom);
                  1: begin
                     // sample extremes, range edges and their outside neighbors
                     case ($urandom_range(5))
                        0: value = '0;
                        1: value = '1;
                        2: value = gen_lo;
                        3: value = gen_hi;
                        4: value = gen_lo - 1'b1;
                        default: value = gen_hi + 1'b1;
                     endcase
                  end
                  default: begin
                     if (gen_lo <= gen_hi)
                        value = SampleBits'($urandom_range(gen_hi, gen_lo));
                     else
                        value = SampleBits'($urandom);
                  end
               endcase
               add_map(value);
            end
         end
      end

      drain();
      $display("requests: %0d table loads, %0d mapped samples checked, %0d of them clamped",
               loads_taken, maps_checked, clamps_seen);
      $display("range settings applied: %0d, cycles with requests held back: %0d",
               settings_applied, input_stalls);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hang guard
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/cmli_pkg.sv
rtl/cmli_seg.sv
rtl/cmli_table.sv
rtl/cmli_blend.sv
rtl/colormap_linear_interp.sv
dv/colormap_linear_interp_test.sv
